>>> design/mbt_pkg.sv
// mbt_pkg: shared constants, operation codes and width helpers for the bag table
// used by the top level and its checker; depends on nothing
package mbt_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IN_W        = 32;
	localparam int OUT_W       = 7;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [OUT_W-1:0]       out_t;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// low VALUE_WIDTH bits of the request value, zero filled when wider
	function automatic value_t to_value(logic [IN_W-1:0] x);
		logic [VALUE_WIDTH+IN_W-1:0] t;
		t = {{VALUE_WIDTH{1'b0}}, x};
		return t[VALUE_WIDTH-1:0];
	endfunction

	// count to result field width, keeping the low bits
	function automatic out_t to_out(cnt_t x);
		logic [CNT_W+OUT_W-1:0] t;
		t = {{OUT_W{1'b0}}, x};
		return t[OUT_W-1:0];
	endfunction

endpackage

>>> design/mbt_ram.sv
// mbt_ram: generic simple dual port ram, one write port and one registered read port
// no package dependency
module mbt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/multiset_bag_table.sv
// multiset_bag_table: fixed capacity unordered multiset held in one value ram
// depends on mbt_pkg and mbt_ram
//
// A request is taken when start is high and busy is low; its result appears, registered,
// in the cycle after it is taken or after the end of a scan, on the result ports for a
// single cycle marked by done, and cannot be held off. Add and clear leave the block
// idle, so a new request can be taken in the very next cycle. Remove and query scan the
// used entries through the single ram read port, one entry per cycle; a remove that
// finds its value ends the scan there, then reads the final entry and writes it into
// the freed slot. After reset the bag is empty; no clearing pass is needed.
module multiset_bag_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [mbt_pkg::IN_W-1:0]   item_value,
	output logic                       done,
	output logic                       success,
	output logic [mbt_pkg::OUT_W-1:0]  match_count,
	output logic signed [mbt_pkg::OUT_W-1:0] first_position,
	output logic [mbt_pkg::OUT_W-1:0]  entries_in_use,
	output logic                       is_empty
);

	import mbt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_MVRD = 4'b0100,
		S_MVWR = 4'b1000
	} state_t;

	state_t state_q;
	cnt_t   count_q;
	cnt_t   a_q;
	logic   vld_s1;
	idx_t   a_s1;
	logic   done_q;

	op_t    op_q;
	value_t val_q;
	logic   fnd_q;
	idx_t   pos_q;
	cnt_t   cnt_q;

	logic   success_q;
	cnt_t   mcnt_q;
	logic   pos_vld_q;
	idx_t   pos_out_q;
	cnt_t   used_q;

	logic   accept;
	op_t    op_in;
	logic   room;
	logic   issue;
	logic   hit;
	cnt_t   last;

	logic   ram_we;
	idx_t   ram_waddr;
	value_t ram_wdata;
	idx_t   ram_raddr;
	value_t ram_rdata;

	logic   res_fire;
	logic   res_ok;
	cnt_t   res_cnt;
	logic   res_pos_vld;
	idx_t   res_pos;
	cnt_t   res_used;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign op_in  = op_t'(operation);
	assign room   = (count_q < CNT_W'(CAPACITY));
	assign issue  = (a_q < count_q);
	assign hit    = vld_s1 && (ram_rdata == val_q);
	assign last   = count_q - CNT_W'(1);

	// add writes at the fill point, the move writes the last entry into the freed slot
	assign ram_we    = (accept && op_in == OP_ADD && room) || (state_q == S_MVWR);
	assign ram_waddr = (state_q == S_MVWR) ? pos_q : count_q[IDX_W-1:0];
	assign ram_wdata = (state_q == S_MVWR) ? ram_rdata : to_value(item_value);
	assign ram_raddr = (state_q == S_SCAN) ? a_q[IDX_W-1:0] : last[IDX_W-1:0];

	mbt_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res_fire    = 1'b0;
		res_ok      = 1'b0;
		res_cnt     = '0;
		res_pos_vld = 1'b0;
		res_pos     = pos_q;
		res_used    = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op_in == OP_ADD) begin
					res_fire = 1'b1;
					res_ok   = room;
					res_used = room ? count_q + CNT_W'(1) : count_q;
				end else if (accept && op_in == OP_CLEAR) begin
					res_fire = 1'b1;
					res_ok   = 1'b1;
					res_used = '0;
				end
			end
			S_SCAN: begin
				// scan over: nothing issued and nothing in flight
				if (!issue && !vld_s1) begin
					res_fire    = 1'b1;
					res_ok      = fnd_q;
					res_cnt     = cnt_q;
					res_pos_vld = fnd_q;
				end
			end
			S_MVRD: begin
			end
			S_MVWR: begin
				res_fire    = 1'b1;
				res_ok      = 1'b1;
				res_pos_vld = 1'b1;
				res_used    = last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			a_q     <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= res_fire;
			unique case (state_q)
				S_IDLE: begin
					a_q    <= '0;
					vld_s1 <= 1'b0;
					if (accept) begin
						case (op_in)
							OP_ADD: begin
								if (room) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_CLEAR: count_q <= '0;
							default:  state_q <= S_SCAN;
						endcase
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						a_q <= a_q + CNT_W'(1);
					end
					if (op_q == OP_REMOVE && hit) begin
						state_q <= S_MVRD;
					end else if (!issue && !vld_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_MVRD: state_q <= S_MVWR;
				S_MVWR: begin
					count_q <= last;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_q[IDX_W-1:0];
		if (accept) begin
			op_q  <= op_in;
			val_q <= to_value(item_value);
			fnd_q <= 1'b0;
			cnt_q <= '0;
		end else if (state_q == S_SCAN && hit) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (!fnd_q) begin
				fnd_q <= 1'b1;
				pos_q <= a_s1;
			end
		end
		if (res_fire) begin
			success_q <= res_ok;
			mcnt_q    <= res_cnt;
			pos_vld_q <= res_pos_vld;
			pos_out_q <= res_pos;
			used_q    <= res_used;
		end
	end

	assign done           = done_q;
	assign success        = success_q;
	assign match_count    = to_out(mcnt_q);
	assign first_position = pos_vld_q ? to_out(CNT_W'(pos_out_q)) : '1;
	assign entries_in_use = to_out(used_q);
	assign is_empty       = (used_q == '0);

endmodule

>>> design/mbt_checker.sv
// mbt_checker: port level checks for the bag table, bound to the top level
// depends on mbt_pkg
module mbt_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [1:0]                operation,
	input logic                      done,
	input logic                      success,
	input logic [mbt_pkg::OUT_W-1:0] match_count,
	input logic [mbt_pkg::OUT_W-1:0] first_position,
	input logic [mbt_pkg::OUT_W-1:0] entries_in_use,
	input logic                      is_empty
);

	import mbt_pkg::*;

	// every transfer is answered next cycle or the block goes busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither answered nor in progress");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_CLEAR |=> done && success && is_empty)
		else $error("clear result wrong");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entries_in_use == '0)))
		else $error("is_empty disagrees with entries_in_use");

	a_matches_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && match_count != '0 |-> success && (first_position != '1))
		else $error("matches reported without a found position");

endmodule

bind multiset_bag_table mbt_checker u_mbt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.operation     (operation),
	.done          (done),
	.success       (success),
	.match_count   (match_count),
	.first_position(first_position),
	.entries_in_use(entries_in_use),
	.is_empty      (is_empty)
);
